>>> rtl/core/xcls_pkg.sv
// shared types and constants for the cross-correlation lag search block
// no dependencies; imported by every module of the block
`default_nettype none

package xcls_pkg;

   localparam int MAX_LAG_DEF   = 32;
   localparam int MAX_PAIRS_DEF = 65536;
   localparam int MIN_PAIRS     = 8;

   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int PEAK_LAG_W = 7;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 2 * SAMPLE_W;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - PEAK_LAG_W - STATUS_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_SHORT = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // controls shared by every lag cell of the chain
   typedef struct packed {
      logic acc_en;
      logic shift;
   } cell_ctrl_type;

   // controls for the running-maximum unit at the chain head
   typedef struct packed {
      logic clear;
      logic take;
   } search_ctrl_type;

endpackage : xcls_pkg

`default_nettype wire

>>> rtl/core/xcls_lag_cell.sv
// one lag cell: registered product and exact accumulator, shifts toward the chain head
// depends on xcls_pkg
`default_nettype none

module xcls_lag_cell #(
   parameter int SUM_W = 48
) (
   input  wire                               clock,
   input  wire                               reset,
   input  xcls_pkg::cell_ctrl_type           ctrl,
   input  wire signed [xcls_pkg::SAMPLE_W-1:0] mul_a,
   input  wire signed [xcls_pkg::SAMPLE_W-1:0] mul_b,
   input  wire signed [SUM_W-1:0]            shift_in,
   output logic signed [SUM_W-1:0]           acc_out
);
   import xcls_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  acc_in;

   assign prod_in = mul_a * mul_b;

   always_comb begin
      priority if (ctrl.shift) begin
         acc_in = shift_in;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule : xcls_lag_cell

`default_nettype wire

>>> rtl/core/xcls_peak_search.sv
// running maximum over the sums leaving the chain head, most negative lag first
// depends on xcls_pkg
`default_nettype none

module xcls_peak_search #(
   parameter int MAX_LAG = 32,
   parameter int SUM_W   = 48,
   parameter int IDX_W   = 7,
   parameter int CNT_W   = 17
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  xcls_pkg::search_ctrl_type           ctrl,
   input  wire signed [SUM_W-1:0]              sum,
   input  wire [IDX_W-1:0]                     idx,
   input  wire [CNT_W-1:0]                     pair_count,
   output logic signed [xcls_pkg::PEAK_LAG_W-1:0] peak_lag
);
   import xcls_pkg::*;

   localparam int CmpW = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int LagW = (IDX_W + 1 > PEAK_LAG_W + 1) ? IDX_W + 1 : PEAK_LAG_W + 1;

   logic                    have_ff;
   logic                    have_in;
   logic signed [SUM_W-1:0] best_ff;
   logic signed [SUM_W-1:0] best_in;
   logic [IDX_W-1:0]        best_idx_ff;
   logic [IDX_W-1:0]        best_idx_in;
   logic [IDX_W-1:0]        mag;
   logic                    eligible;
   logic                    take_now;
   logic [LagW-1:0]         lag_full;

   // |lag| of the sum now at the head, only lags shorter than the run count
   assign mag      = (idx < IDX_W'(MAX_LAG)) ? IDX_W'(MAX_LAG) - idx : idx - IDX_W'(MAX_LAG);
   assign eligible = CmpW'(mag) < CmpW'(pair_count);
   // strict compare keeps the earlier, more negative lag on a tie
   assign take_now = ctrl.take && eligible && (!have_ff || (sum > best_ff));

   always_comb begin
      have_in     = have_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      priority if (ctrl.clear) begin
         have_in     = 1'b0;
         best_idx_in = IDX_W'(MAX_LAG);
      end else if (take_now) begin
         have_in     = 1'b1;
         best_in     = sum;
         best_idx_in = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff     <= 1'b0;
         best_idx_ff <= IDX_W'(MAX_LAG);
      end else begin
         have_ff     <= have_in;
         best_idx_ff <= best_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign lag_full = LagW'(best_idx_ff) - LagW'(MAX_LAG);
   assign peak_lag = lag_full[PEAK_LAG_W-1:0];

endmodule : xcls_peak_search

`default_nettype wire

>>> rtl/core/cross_correlation_lag_search_top.sv
// top level of the cross-correlation lag search: delay lines, lag cell chain, control
// depends on xcls_pkg, xcls_lag_cell and xcls_peak_search
`default_nettype none

// usage
//   req channel: one transaction per sample pair, tdata = {sample_b, sample_a},
//   tlast marks the final pair of a run
//   rsp channel: one transaction per run, tdata = {pad, status, peak_lag}
//   within a run a pair is taken every cycle; each of the 2*MAX_LAG+1 lag cells
//   does one multiply-accumulate per pair (product register, then accumulator)
//   after the final pair the block drains the product stage, then shifts all
//   sums through the peak search at the chain head, one per cycle, then loads
//   the result register
//   the result is valid once the scan is done and the result register is loaded;
//   req_tready is low from the final pair until then
//   the scan shifts zeros into the chain, so the sums are clear for the next run
//   the result waits in its register while rsp_tready is low; the next run is
//   taken meanwhile, and only its own end waits for the register to free up
//   pairs past MAX_PAIRS are dropped and the result is flagged as overflow
//   reset clears delay lines, sums, counters and the result valid
module cross_correlation_lag_search_top #(
   parameter int MAX_LAG   = xcls_pkg::MAX_LAG_DEF,
   parameter int MAX_PAIRS = xcls_pkg::MAX_PAIRS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [xcls_pkg::REQ_DATA_W-1:0]     req_tdata,   // sample_a [15:0], sample_b [31:16]
   input  wire                                req_tlast,   // last_pair
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [xcls_pkg::RSP_DATA_W-1:0]    rsp_tdata    // peak_lag [6:0], status [8:7], zero pad
);
   import xcls_pkg::*;

   localparam int NumLags = 2 * MAX_LAG + 1;
   localparam int IdxW    = $clog2(NumLags);
   localparam int CntW    = $clog2(MAX_PAIRS + 1);
   localparam int SumW    = PROD_W + $clog2(MAX_PAIRS);

   // input fields
   logic signed [SAMPLE_W-1:0] sample_a;
   logic signed [SAMPLE_W-1:0] sample_b;
   assign sample_a = req_tdata[SAMPLE_W-1:0];
   assign sample_b = req_tdata[2*SAMPLE_W-1:SAMPLE_W];

   state_type state_ff;
   state_type state_in;

   logic            accept;
   logic            keep;
   logic            load_rsp;
   logic            hist_clear;
   cell_ctrl_type   cell_ctrl;
   search_ctrl_type search_ctrl;

   logic            prod_vld_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            ovf_ff;
   logic            ovf_in;
   logic [IdxW-1:0] idx_ff;
   logic [IdxW-1:0] idx_in;
   logic            scan_done;

   // delay lines, newest first
   logic signed [SAMPLE_W-1:0] hist_a_ff [MAX_LAG];
   logic signed [SAMPLE_W-1:0] hist_b_ff [MAX_LAG];

   logic signed [SumW-1:0] acc_w [NumLags];
   logic signed [PEAK_LAG_W-1:0] peak_lag;

   logic                         rsp_tvalid_ff;
   logic signed [PEAK_LAG_W-1:0] rsp_lag_ff;
   status_type                   rsp_status_ff;
   status_type                   status_now;

   assign accept    = req_tvalid && req_tready;
   assign keep      = accept && (count_ff < CntW'(MAX_PAIRS));
   assign scan_done = (idx_ff == IdxW'(NumLags - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (accept && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready         = 1'b0;
      hist_clear         = 1'b0;
      load_rsp           = 1'b0;
      cell_ctrl.acc_en   = prod_vld_ff;
      cell_ctrl.shift    = 1'b0;
      search_ctrl.clear  = 1'b0;
      search_ctrl.take   = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
         end
         ST_DRAIN: begin
            hist_clear        = 1'b1;
            search_ctrl.clear = 1'b1;
         end
         ST_SCAN: begin
            cell_ctrl.shift  = 1'b1;
            search_ctrl.take = 1'b1;
         end
         ST_EMIT: begin
            load_rsp = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   // run counters
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      priority if (load_rsp) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (keep) begin
         count_in = count_ff + CntW'(1);
      end else if (accept) begin
         ovf_in = 1'b1;
      end
   end

   assign idx_in = (state_ff == ST_SCAN) ? idx_ff + IdxW'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         idx_ff      <= '0;
      end else begin
         prod_vld_ff <= keep;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         idx_ff      <= idx_in;
      end
   end

   // delay lines shift on every kept pair, cleared once the run's products are taken
   always_ff @(posedge clock) begin
      if (reset || hist_clear) begin
         for (int k = 0; k < MAX_LAG; k++) begin
            hist_a_ff[k] <= '0;
            hist_b_ff[k] <= '0;
         end
      end else if (keep) begin
         hist_a_ff[0] <= sample_a;
         hist_b_ff[0] <= sample_b;
         for (int k = 1; k < MAX_LAG; k++) begin
            hist_a_ff[k] <= hist_a_ff[k-1];
            hist_b_ff[k] <= hist_b_ff[k-1];
         end
      end
   end

   // cell j holds lag j - MAX_LAG; the chain shifts toward cell 0
   for (genvar j = 0; j < NumLags; j++) begin : g_cell
      logic signed [SAMPLE_W-1:0] op_a;
      logic signed [SAMPLE_W-1:0] op_b;
      logic signed [SumW-1:0]     next_acc;

      if (j == MAX_LAG) begin : g_zero
         assign op_a = sample_a;
         assign op_b = sample_b;
      end else if (j > MAX_LAG) begin : g_pos
         assign op_a = hist_a_ff[j-MAX_LAG-1];
         assign op_b = sample_b;
      end else begin : g_neg
         assign op_a = sample_a;
         assign op_b = hist_b_ff[MAX_LAG-j-1];
      end

      if (j == NumLags - 1) begin : g_tail
         assign next_acc = '0;
      end else begin : g_link
         assign next_acc = acc_w[j+1];
      end

      xcls_lag_cell #(
         .SUM_W (SumW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .mul_a    (op_a),
         .mul_b    (op_b),
         .shift_in (next_acc),
         .acc_out  (acc_w[j])
      );
   end

   xcls_peak_search #(
      .MAX_LAG (MAX_LAG),
      .SUM_W   (SumW),
      .IDX_W   (IdxW),
      .CNT_W   (CntW)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (search_ctrl),
      .sum        (acc_w[0]),
      .idx        (idx_ff),
      .pair_count (count_ff),
      .peak_lag   (peak_lag)
   );

   // result register
   always_comb begin
      priority if (count_ff < CntW'(MIN_PAIRS)) begin
         status_now = STATUS_TOO_SHORT;
      end else if (ovf_ff) begin
         status_now = STATUS_OVERFLOW;
      end else begin
         status_now = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_now;
         rsp_lag_ff    <= (status_now == STATUS_TOO_SHORT) ? '0 : peak_lag;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_lag_ff};

endmodule : cross_correlation_lag_search_top

`default_nettype wire
